FILE: design/ntc_pkg.sv
// Package for the NTC temperature converter: payload types, constants,
// and the log2 mantissa table function. No dependencies.
`default_nettype none
package ntc_pkg;
	localparam int LogTableEntries = 256;
	localparam int IdxW = $clog2(LogTableEntries);
	localparam logic [29:0] Ln2Q30 = 30'd744261118;
	localparam logic [17:0] FaultTemp = -18'sd99900;
	localparam logic [17:0] TempMax = 18'd99899;
	localparam logic [17:0] ZeroCCentiK = 18'd27315;
	localparam logic [17:0] KcMax = 18'd127214;

	// B/T0 in Q30 = B*BetaT0Whole + floor((B*BetaT0Rem + BetaT0Half) / 5963);
	// the inner quotient is exact as (x * BetaT0Recip) >> 40 for x below 2^27
	localparam logic [21:0] BetaT0Whole = 22'd3601347;
	localparam logic [12:0] BetaT0Rem = 13'd4319;
	localparam logic [11:0] BetaT0Half = 12'd2981;
	localparam logic [27:0] BetaT0Recip = 28'd184389004;

	localparam logic [1:0] CFG_FIXED = 2'd0;
	localparam logic [1:0] CFG_NOMINAL = 2'd1;
	localparam logic [1:0] CFG_BETA = 2'd2;

	typedef struct packed {
		logic signed [15:0] sensor_voltage;
		logic signed [15:0] supply_voltage;
	} ntc_in_t;

	typedef struct packed {
		logic signed [17:0] temperature_centi_c;
		logic fault;
	} ntc_out_t;

	// log2(1 + i/N) in Q30 by repeated squaring, truncated
	function automatic logic [30:0] log_tab(input logic [IdxW:0] i);
		logic [63:0] m;
		logic [30:0] res;
		res = '0;
		if (i == (IdxW+1)'(LogTableEntries)) begin
			res = 31'h4000_0000;
		end else begin
			m = 64'h4000_0000 + ((64'(i) << 30) / LogTableEntries);
			for (int b = 29; b >= 0; b--) begin
				m = (m * m) >> 30;
				if (m >= 64'h8000_0000) begin
					res[b] = 1'b1;
					m = m >> 1;
				end
			end
		end
		return res;
	endfunction
endpackage
`default_nettype wire

FILE: design/ntc_temperature_converter_top.sv
// Top level of the NTC temperature converter (Beta equation).
// Depends on ntc_pkg, ntc_log2, ntc_divider.
`default_nettype none
// Fully pipelined: a sample pair can start every cycle, and its result
// appears on result/done after the log pipeline, lnx scaling, the 19-stage
// divider and a final stage. Results cannot be held off; take
// each transfer in the cycle done is high. Write configuration only idle;
// B/T0 follows a Beta write through bt0_whole_q, bt0_base_q and bt0_q, well before any item uses it.
module ntc_temperature_converter_top import ntc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire ntc_in_t operand,
	output logic done,
	output ntc_out_t result,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [19:0] cfg_data
);
	localparam int Lat = 26;
	logic [19:0] rf_q, r25_q;
	logic [13:0] beta_q;
	logic [Lat-1:0] vld_q;
	logic [Lat-1:0] flt_q;
	logic signed [15:0] s, v;
	logic fault_in;
	logic [19:0] rf, r25;
	logic [13:0] b;
	logic [39:0] n_num, n_den;
	logic [35:0] l_num, l_den;
	logic neg_s4, neg_s5, neg_s6;
	logic [35:0] mag_s4;
	logic [59:0] lnq_s5;
	logic [35:0] lnq_s6;
	logic [35:0] bt0_whole_q, bt0_base_q, bt0_q;
	logic [26:0] bt0_frac_q;
	logic [54:0] bt0_prod_q;
	logic [52:0] num;
	logic signed [37:0] den_s7;
	logic [52:0] num_s7;
	logic [Lat-1:0] hot_q;
	logic hot_now;
	logic [17:0] kc;

	assign busy = 1'b0;
	assign s = operand.sensor_voltage;
	assign v = operand.supply_voltage;
	assign fault_in = (s <= 0) || (s >= v);
	assign rf = (rf_q == '0) ? 20'd1 : rf_q;
	assign r25 = (r25_q == '0) ? 20'd1 : r25_q;
	assign b = (beta_q == '0) ? 14'd1 : beta_q;
	assign n_num = 40'(s[14:0]) * 40'(rf);
	assign n_den = 40'(17'(v) - 17'(s)) * 40'(r25);
	// 100*B*2^30 depends only on configuration
	assign num = 53'({21'(b) * 21'd100, 30'd0});
	assign hot_now = neg_s6 ? (lnq_s6 >= bt0_q) : 1'b0;

	ntc_log2 u_lnum (.clk, .n(n_num), .y(l_num));
	ntc_log2 u_lden (.clk, .n(n_den), .y(l_den));

	// hold configuration; accept writes any cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q <= 20'd10000;
			r25_q <= 20'd10000;
			beta_q <= 14'd3950;
			vld_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIXED: rf_q <= cfg_data;
					CFG_NOMINAL: r25_q <= cfg_data;
					CFG_BETA: beta_q <= cfg_data[13:0];
					default: ;
				endcase
			end
			vld_q <= {vld_q[Lat-2:0], start};
		end
	end

	// advance datapath after the log stages
	always_ff @(posedge clk) begin
		// B/T0 in Q30, registered: whole and fractional parts, then reciprocal product, then their sum
		bt0_whole_q <= 36'(b) * 36'(BetaT0Whole);
		bt0_frac_q <= 27'(b) * 27'(BetaT0Rem) + 27'(BetaT0Half);
		bt0_base_q <= bt0_whole_q;
		bt0_prod_q <= 55'(bt0_frac_q) * 55'(BetaT0Recip);
		bt0_q <= bt0_base_q + 36'(bt0_prod_q >> 40);

		flt_q <= {flt_q[Lat-2:0], fault_in};
		neg_s4 <= l_num < l_den;
		mag_s4 <= (l_num < l_den) ? l_den - l_num : l_num - l_den;
		neg_s5 <= neg_s4;
		lnq_s5 <= 60'(mag_s4 >> 6) * 60'(Ln2Q30);
		neg_s6 <= neg_s5;
		lnq_s6 <= 36'(lnq_s5 >> 24);
		den_s7 <= neg_s6 ? 38'(bt0_q) - 38'(lnq_s6) : 38'(bt0_q) + 38'(lnq_s6);
		num_s7 <= num;
		// denominator at or below zero lines up with den_s7
		hot_q <= {hot_q[Lat-2:6], hot_now, 6'd0};
	end

	ntc_divider u_div (.clk, .num(num_s7), .den(den_s7[36:0]), .quo(kc));

	// drop into the output register in the cycle after the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[Lat-1];
		end
	end

	always_ff @(posedge clk) begin
		result.fault <= flt_q[Lat-1];
		if (flt_q[Lat-1]) result.temperature_centi_c <= FaultTemp;
		else if (hot_q[Lat-1] || kc > KcMax) result.temperature_centi_c <= TempMax;
		else result.temperature_centi_c <= kc - ZeroCCentiK;
	end
endmodule
`default_nettype wire

FILE: design/ntc_log2.sv
// Three-stage pipelined log2 in Q30 of a 40-bit integer.
// Depends on ntc_pkg (table function).
`default_nettype none
module ntc_log2 import ntc_pkg::*; (
	input wire logic clk,
	input wire logic [39:0] n,
	output logic [35:0] y
);
	logic [5:0] p;
	logic [39:0] nn, frac;
	logic [5:0] p_s1;
	logic [IdxW-1:0] idx_s1;
	logic [19:0] r_s1;
	logic [5:0] p_s2;
	logic [19:0] r_s2;
	logic [30:0] lo_s2, hi_s2;
	logic [50:0] prod;
	logic [30:0] tab [0:LogTableEntries];

	// constant mantissa table, evaluated at elaboration
	for (genvar g = 0; g <= LogTableEntries; g++) begin : g_tab
		localparam logic [30:0] Entry = log_tab((IdxW+1)'(g));
		assign tab[g] = Entry;
	end

	always_comb begin
		nn = (n == '0) ? 40'd1 : n;
		p = '0;
		for (int k = 0; k < 40; k++) if (nn[k]) p = 6'(k);
		frac = nn << (6'd40 - p);
	end

	always_ff @(posedge clk) begin
		p_s1 <= p;
		idx_s1 <= frac[39 -: IdxW];
		r_s1 <= frac[39-IdxW -: 20];
		p_s2 <= p_s1;
		r_s2 <= r_s1;
		lo_s2 <= tab[{1'b0, idx_s1}];
		hi_s2 <= tab[{1'b0, idx_s1} + 1'b1];
		y <= {p_s2, 30'd0} + 36'(lo_s2) + 36'(prod >> 20);
	end

	assign prod = 51'(hi_s2 - lo_s2) * 51'(r_s2);
endmodule
`default_nettype wire

FILE: design/ntc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, rounded half up.
// Depends on ntc_pkg.
`default_nettype none
module ntc_divider import ntc_pkg::*; (
	input wire logic clk,
	input wire logic [52:0] num,
	input wire logic [36:0] den,
	output logic [17:0] quo
);
	// quotient bits [17:0] of (2num+den)/(2den); dividend is 55 bits
	logic [54:0] rem_s [0:18];
	logic [37:0] d_s [0:18];
	logic [17:0] q_s [0:18];

	always_ff @(posedge clk) begin
		rem_s[0] <= {num, 1'b0} + 55'(den);
		d_s[0] <= {den, 1'b0};
		q_s[0] <= '0;
	end

	for (genvar k = 0; k < 18; k++) begin : g_st
		logic [54:0] sh;
		assign sh = 55'(d_s[k]) << (17 - k);
		always_ff @(posedge clk) begin
			d_s[k+1] <= d_s[k];
			if (rem_s[k] >= sh && (d_s[k] >> (55 - 17 + k)) == '0) begin
				rem_s[k+1] <= rem_s[k] - sh;
				q_s[k+1] <= q_s[k] | (18'd1 << (17 - k));
			end else begin
				rem_s[k+1] <= rem_s[k];
				q_s[k+1] <= q_s[k];
			end
		end
	end

	// saturate when quotient exceeds 18 bits
	always_comb quo = (rem_s[18] >= 55'(d_s[18])) ? '1 : q_s[18];
endmodule
`default_nettype wire
